// ----- rtl/fmti_pkg.sv -----
// Shared types and constants of the trilinear field map lookup.
package fmti_pkg;

  localparam int unsigned NX_DEF        = 32;
  localparam int unsigned NY_DEF        = 32;
  localparam int unsigned NZ_DEF        = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH   = 16;

  localparam int unsigned IDX_W    = 8;
  localparam int unsigned FRAC_W   = 25;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned BANKS    = 8;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH   = 3'd6;

  localparam logic signed [31:0] ROT_SIN = 32'sd41218596;
  localparam logic signed [31:0] ROT_COS = 32'sd1072950387;
  localparam logic signed [32:0] OFS_X   = 33'sd394978;
  localparam logic signed [32:0] OFS_Z   = 33'sd10281569;

  typedef struct packed {
    logic               cmd;
    logic [14:0]        entry_index;
    logic signed [23:0] sample_x;
    logic signed [23:0] sample_y;
    logic signed [23:0] sample_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
    logic               in_region;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic [31:0]        inv_step_x;
    logic [31:0]        inv_step_y;
    logic [31:0]        inv_step_z;
    logic signed [31:0] strength;
  } cfg_t;

  typedef struct packed {
    logic                         cmd;
    logic                         in_region;
    logic [2:0][IDX_W-1:0]        idx;
    logic [2:0][FRAC_W-1:0]       frac;
    logic [2:0][SAMPLE_W-1:0]     sample;
  } job_t;

endpackage

// ----- rtl/fmti_queue.sv -----
// Register-based word queue with occupancy count.
module fmti_queue #(
  parameter type word_t = logic,
  parameter int unsigned DEPTH = fmti_pkg::QUEUE_DEPTH,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  word_t         word_i,
  input  logic          pop_i,
  output word_t         word_o,
  output logic          empty_o,
  output logic [CW-1:0] count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  word_t         mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? ((wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop_i ? ((rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= word_i;
    end
  end

  assign word_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop_i && cnt_q == CW'(DEPTH)))
    else $error("queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && cnt_q == '0))
    else $error("queue underflow");

endmodule

// ----- rtl/fmti_front.sv -----
// Front end: rotation into map frame, grid location, load address decode.
module fmti_front #(
  parameter int unsigned NX        = fmti_pkg::NX_DEF,
  parameter int unsigned NY        = fmti_pkg::NY_DEF,
  parameter int unsigned NZ        = fmti_pkg::NZ_DEF,
  parameter int unsigned FRAC_BITS = fmti_pkg::FRAC_BITS_DEF,
  parameter int unsigned MID_DEPTH = fmti_pkg::QUEUE_DEPTH,
  localparam int unsigned CW = $clog2(MID_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fmti_pkg::cfg_t     cfg_i,
  input  logic               push_i,
  input  fmti_pkg::in_word_t word_i,
  output logic               full_o,
  input  logic [CW-1:0]      mid_count_i,
  output logic               mid_push_o,
  output fmti_pkg::job_t     mid_word_o
);

  localparam int unsigned IW    = fmti_pkg::IDX_W;
  localparam int unsigned FW    = fmti_pkg::FRAC_W;
  localparam int unsigned CW1   = CW + 1;
  localparam int unsigned S     = 32 - FRAC_BITS;
  localparam int unsigned SL    = (S <= 16) ? 16 - S : 0;
  localparam int unsigned SR    = (S <= 16) ? S : 16;
  localparam int unsigned SP    = (S <= 16) ? 0 : S - 16;
  localparam int unsigned CELLS = NX * NY * NZ;
  localparam logic [24:0] RZ = 25'(((32'd1 << 24) + NZ - 1) / NZ);
  localparam logic [24:0] RY = 25'(((32'd1 << 24) + NY - 1) / NY);
  localparam int unsigned NM1 [3] = '{NX - 1, NY - 1, NZ - 1};

  logic          accept;
  logic [6:1]    v_q;
  logic [CW-1:0] cnt_q, cnt_d;

  // stage 1
  logic               s1_cmd_q, s1_ok_q;
  logic [14:0]        s1_e_q;
  logic [2:0][23:0]   s1_smp_q;
  logic signed [32:0] s1_u_q, s1_w_q;
  logic signed [35:0] s1_dy_q;
  logic [39:0]        s1_m1_q;
  // stage 2
  logic               s2_cmd_q, s2_ok_q;
  logic [2:0][23:0]   s2_smp_q;
  logic signed [64:0] s2_uc_q, s2_ws_q, s2_us_q, s2_wc_q;
  logic signed [35:0] s2_dy_q;
  logic [14:0]        s2_q1_q;
  logic [IW-1:0]      s2_iz_q;
  logic [39:0]        s2_m2_q;
  logic [14:0]        q1;
  // stage 3
  logic               s3_cmd_q, s3_ok_q;
  logic [2:0][23:0]   s3_smp_q;
  logic signed [34:0] s3_mx_q, s3_mz_q;
  logic signed [35:0] s3_dy_q;
  logic [2:0][IW-1:0] s3_li_q;
  logic signed [64:0] sum_x, sum_z;
  logic [14:0]        q2;
  // stage 4
  logic               s4_cmd_q, s4_ok_q;
  logic [2:0][23:0]   s4_smp_q;
  logic [2:0][IW-1:0] s4_li_q;
  logic signed [35:0] s4_d_q [3];
  // stage 5
  logic               s5_cmd_q, s5_ok_q;
  logic [2:0][23:0]   s5_smp_q;
  logic [2:0][IW-1:0] s5_li_q;
  logic [2:0]         s5_neg_q;
  logic [49:0]        s5_a_q [3];
  logic [49:0]        s5_b_q [3];
  logic [31:0]        inv [3];
  // stage 6
  fmti_pkg::job_t     s6_q, job_d;
  logic               s6_ok_q;

  assign accept = push_i && !full_o;
  assign full_o = (CW1'(cnt_q) + CW1'(mid_count_i)) >= CW1'(MID_DEPTH);
  assign cnt_d  = cnt_q + CW'(accept) - CW'(v_q[6]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      cnt_q <= '0;
    end else begin
      v_q   <= {v_q[5:1], accept};
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    inv[0] = cfg_i.inv_step_x;
    inv[1] = cfg_i.inv_step_y;
    inv[2] = cfg_i.inv_step_z;
    q1     = s1_m1_q[38:24];
    q2     = s2_m2_q[38:24];
    sum_x  = s2_uc_q - s2_ws_q + 65'sd536870912;
    sum_z  = s2_us_q + s2_wc_q + 65'sd536870912;
  end

  always_comb begin
    logic [63:0] p;
    logic [63:0] pi;
    logic        inr;
    job_d           = '0;
    job_d.cmd       = s5_cmd_q;
    job_d.sample    = s5_smp_q;
    inr             = 1'b1;
    for (int k = 0; k < 3; k++) begin
      p  = ((64'(s5_a_q[k]) << SL) + (64'(s5_b_q[k]) >> SR)) >> SP;
      pi = p >> FRAC_BITS;
      if (s5_neg_q[k] || p > (64'(NM1[k]) << FRAC_BITS)) begin
        inr = 1'b0;
      end
      if (pi >= 64'(NM1[k])) begin
        job_d.idx[k]  = IW'(NM1[k] - 1);
        job_d.frac[k] = FW'(64'd1 << FRAC_BITS);
      end else begin
        job_d.idx[k]  = IW'(pi);
        job_d.frac[k] = FW'(p[FRAC_BITS-1:0]);
      end
    end
    if (s5_cmd_q == fmti_pkg::CMD_LOAD) begin
      job_d.idx  = s5_li_q;
      job_d.frac = '0;
      inr        = 1'b0;
    end else if (!inr) begin
      job_d.idx  = '0;
      job_d.frac = '0;
    end
    job_d.in_region = inr;
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q    <= word_i.cmd;
    s1_ok_q     <= 32'(word_i.entry_index) < 32'(CELLS);
    s1_e_q      <= word_i.entry_index;
    s1_smp_q    <= {word_i.sample_z, word_i.sample_y, word_i.sample_x};
    s1_u_q      <= 33'(word_i.pos_x) - fmti_pkg::OFS_X;
    s1_w_q      <= 33'(word_i.pos_z) - fmti_pkg::OFS_Z;
    s1_dy_q     <= 36'(word_i.pos_y) - 36'(cfg_i.origin_y);
    s1_m1_q     <= 40'(word_i.entry_index) * 40'(RZ);

    s2_cmd_q    <= s1_cmd_q;
    s2_ok_q     <= s1_ok_q;
    s2_smp_q    <= s1_smp_q;
    s2_uc_q     <= 65'(s1_u_q) * 65'(fmti_pkg::ROT_COS);
    s2_ws_q     <= 65'(s1_w_q) * 65'(fmti_pkg::ROT_SIN);
    s2_us_q     <= 65'(s1_u_q) * 65'(fmti_pkg::ROT_SIN);
    s2_wc_q     <= 65'(s1_w_q) * 65'(fmti_pkg::ROT_COS);
    s2_dy_q     <= s1_dy_q;
    s2_q1_q     <= q1;
    s2_iz_q     <= IW'(s1_e_q - 15'(q1 * 15'(NZ)));
    s2_m2_q     <= 40'(q1) * 40'(RY);

    s3_cmd_q    <= s2_cmd_q;
    s3_ok_q     <= s2_ok_q;
    s3_smp_q    <= s2_smp_q;
    s3_mx_q     <= sum_x[64:30];
    s3_mz_q     <= sum_z[64:30];
    s3_dy_q     <= s2_dy_q;
    s3_li_q[0]  <= IW'(q2);
    s3_li_q[1]  <= IW'(s2_q1_q - 15'(q2 * 15'(NY)));
    s3_li_q[2]  <= s2_iz_q;

    s4_cmd_q    <= s3_cmd_q;
    s4_ok_q     <= s3_ok_q;
    s4_smp_q    <= s3_smp_q;
    s4_li_q     <= s3_li_q;
    s4_d_q[0]   <= 36'(s3_mx_q) - 36'(cfg_i.origin_x);
    s4_d_q[1]   <= s3_dy_q;
    s4_d_q[2]   <= 36'(s3_mz_q) - 36'(cfg_i.origin_z);

    s5_cmd_q    <= s4_cmd_q;
    s5_ok_q     <= s4_ok_q;
    s5_smp_q    <= s4_smp_q;
    s5_li_q     <= s4_li_q;
    for (int k = 0; k < 3; k++) begin
      s5_neg_q[k] <= s4_d_q[k][35];
      s5_a_q[k]   <= 50'(s4_d_q[k][33:0]) * 50'(inv[k][31:16]);
      s5_b_q[k]   <= 50'(s4_d_q[k][33:0]) * 50'(inv[k][15:0]);
    end

    s6_q        <= job_d;
    s6_ok_q     <= s5_ok_q;
  end

  assign mid_push_o = v_q[6] && (s6_q.cmd == fmti_pkg::CMD_QUERY || s6_ok_q);
  assign mid_word_o = s6_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW1'(cnt_q) + CW1'(mid_count_i)) <= CW1'(MID_DEPTH))
    else $error("front credit exceeded");

endmodule

// ----- rtl/fmti_back.sv -----
// Back end: parity-banked grid memory, trilinear blend, strength scaling.
module fmti_back #(
  parameter int unsigned NX        = fmti_pkg::NX_DEF,
  parameter int unsigned NY        = fmti_pkg::NY_DEF,
  parameter int unsigned NZ        = fmti_pkg::NZ_DEF,
  parameter int unsigned FRAC_BITS = fmti_pkg::FRAC_BITS_DEF,
  parameter int unsigned OUT_DEPTH = fmti_pkg::QUEUE_DEPTH,
  localparam int unsigned CW = $clog2(OUT_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fmti_pkg::cfg_t      cfg_i,
  input  fmti_pkg::job_t      mid_word_i,
  input  logic                mid_empty_i,
  output logic                mid_pop_o,
  input  logic [CW-1:0]       out_count_i,
  output logic                out_push_o,
  output fmti_pkg::out_word_t out_word_o
);

  localparam int unsigned IW   = fmti_pkg::IDX_W;
  localparam int unsigned FW   = fmti_pkg::FRAC_W;
  localparam int unsigned NB   = fmti_pkg::BANKS;
  localparam int unsigned CW1  = CW + 1;
  localparam int unsigned HX   = (NX + 1) / 2;
  localparam int unsigned HY   = (NY + 1) / 2;
  localparam int unsigned HZ   = (NZ + 1) / 2;
  localparam int unsigned BANK_DEPTH = HX * HY * HZ;
  localparam int unsigned BAW  = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  function automatic logic signed [23:0] lerp(logic signed [23:0] a,
                                               logic signed [23:0] b,
                                               logic [FW-1:0] f);
    logic signed [25:0] fs;
    logic signed [24:0] df;
    logic signed [51:0] v;
    fs = $signed({1'b0, f});
    df = 25'(b) - 25'(a);
    v  = (52'(a) <<< FRAC_BITS) + 52'(df) * 52'(fs) + (52'sd1 <<< (FRAC_BITS - 1));
    return v[FRAC_BITS +: 24];
  endfunction

  logic              issue;
  logic [9:1]        v_q;
  fmti_pkg::job_t    jb_q [1:9];
  logic [CW-1:0]     cnt_q, cnt_d;

  logic [15:0]       t_d [NB];
  logic [IW-1:0]     hz_d [NB];
  logic [15:0]       t_q [NB];
  logic [IW-1:0]     hz_q [NB];
  logic [BAW-1:0]    addr_q [NB];
  logic [NB-1:0]     we_q;
  logic [71:0]       rd_q [NB];

  logic signed [23:0] cz_q [2][2][3];
  logic signed [23:0] cy_q [2][3];
  logic signed [23:0] cx_q [3];
  logic signed [55:0] pr_q [3];
  fmti_pkg::out_word_t res_q;
  logic signed [31:0]  fld [3];

  assign issue     = !mid_empty_i && ((CW1'(cnt_q) + CW1'(out_count_i)) < CW1'(OUT_DEPTH));
  assign mid_pop_o = issue;
  assign out_push_o = v_q[9] && (jb_q[9].cmd == fmti_pkg::CMD_QUERY);
  assign cnt_d     = cnt_q + CW'(issue && mid_word_i.cmd == fmti_pkg::CMD_QUERY)
                   - CW'(out_push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      cnt_q <= '0;
    end else begin
      v_q   <= {v_q[8:1], issue};
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    logic [2:0]    lb;
    logic [IW-1:0] hx, hy;
    for (int k = 0; k < NB; k++) begin
      lb      = 3'(k);
      hx      = IW'((9'(jb_q[1].idx[0]) + 9'(lb[2] ^ jb_q[1].idx[0][0])) >> 1);
      hy      = IW'((9'(jb_q[1].idx[1]) + 9'(lb[1] ^ jb_q[1].idx[1][0])) >> 1);
      hz_d[k] = IW'((9'(jb_q[1].idx[2]) + 9'(lb[0] ^ jb_q[1].idx[2][0])) >> 1);
      t_d[k]  = 16'(32'(hx) * HY + 32'(hy));
    end
  end

  always_ff @(posedge clk_i) begin
    logic [2:0] bk;
    jb_q[1] <= mid_word_i;
    for (int s = 2; s <= 9; s++) begin
      jb_q[s] <= jb_q[s-1];
    end
    for (int k = 0; k < NB; k++) begin
      t_q[k]    <= t_d[k];
      hz_q[k]   <= hz_d[k];
      addr_q[k] <= BAW'(32'(t_q[k]) * HZ + 32'(hz_q[k]));
      we_q[k]   <= v_q[2] && jb_q[2].cmd == fmti_pkg::CMD_LOAD
                   && 3'(k) == {jb_q[2].idx[0][0], jb_q[2].idx[1][0], jb_q[2].idx[2][0]};
    end
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        for (int c = 0; c < 3; c++) begin
          bk = {1'(i) ^ jb_q[4].idx[0][0], 1'(j) ^ jb_q[4].idx[1][0],
                jb_q[4].idx[2][0]};
          cz_q[i][j][c] <= lerp(rd_q[bk][c*24 +: 24],
                                rd_q[{bk[2:1], ~bk[0]}][c*24 +: 24],
                                jb_q[4].frac[2]);
        end
      end
    end
    for (int i = 0; i < 2; i++) begin
      for (int c = 0; c < 3; c++) begin
        cy_q[i][c] <= lerp(cz_q[i][0][c], cz_q[i][1][c], jb_q[5].frac[1]);
      end
    end
    for (int c = 0; c < 3; c++) begin
      cx_q[c] <= lerp(cy_q[0][c], cy_q[1][c], jb_q[6].frac[0]);
      pr_q[c] <= 56'(cx_q[c]) * 56'(cfg_i.strength);
    end
    res_q.field_x   <= jb_q[8].in_region ? fld[0] : '0;
    res_q.field_y   <= jb_q[8].in_region ? fld[1] : '0;
    res_q.field_z   <= jb_q[8].in_region ? fld[2] : '0;
    res_q.in_region <= jb_q[8].in_region;
  end

  always_comb begin
    logic signed [56:0] sr;
    for (int c = 0; c < 3; c++) begin
      sr = 57'(pr_q[c]) + 57'sd32768;
      if (sr[56:47] == '0 || sr[56:47] == '1) begin
        fld[c] = sr[47:16];
      end else if (sr[56]) begin
        fld[c] = 32'sh80000000;
      end else begin
        fld[c] = 32'sh7fffffff;
      end
    end
  end

  for (genvar g = 0; g < NB; g++) begin : g_bank
    logic [71:0] mem_q [BANK_DEPTH];
    always_ff @(posedge clk_i) begin
      if (we_q[g]) begin
        mem_q[addr_q[g]] <= jb_q[3].sample;
      end
      rd_q[g] <= mem_q[addr_q[g]];
    end
  end

  assign out_word_o = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW1'(cnt_q) + CW1'(out_count_i)) <= CW1'(OUT_DEPTH))
    else $error("back credit exceeded");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(we_q))
    else $error("load wrote more than one bank");

endmodule

// ----- rtl/field_map_trilinear_interp_unit.sv -----
// Top level of the trilinear field map lookup: config registers and queues.
// An accepted query goes through the front pipeline, the middle queue and the
// back pipeline to the result queue; loads produce no word.
// Throughput: one word per cycle when not held back by the credit loops around
// the 16-entry middle and result queues.
// Reset: control state and queues clear, registers take their reset values;
// grid memory is not cleared.
module field_map_trilinear_interp_unit #(
  parameter int unsigned NX        = fmti_pkg::NX_DEF,
  parameter int unsigned NY        = fmti_pkg::NY_DEF,
  parameter int unsigned NZ        = fmti_pkg::NZ_DEF,
  parameter int unsigned FRAC_BITS = fmti_pkg::FRAC_BITS_DEF,
  parameter int unsigned MID_DEPTH = fmti_pkg::QUEUE_DEPTH,
  parameter int unsigned OUT_DEPTH = fmti_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  fmti_pkg::in_word_t                  in_word_i,
  output logic                                empty,
  input  logic                                pop,
  output fmti_pkg::out_word_t                 out_word_o,
  input  logic                                cfg_we_i,
  input  logic [fmti_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fmti_pkg::CFG_W-1:0]          cfg_wdata_i
);

  localparam int unsigned MCW = $clog2(MID_DEPTH + 1);
  localparam int unsigned OCW = $clog2(OUT_DEPTH + 1);

  fmti_pkg::cfg_t      cfg_q;
  logic                mid_push, mid_pop, mid_empty;
  fmti_pkg::job_t      mid_in, mid_out;
  logic [MCW-1:0]      mid_count;
  logic                out_push, out_pop;
  fmti_pkg::out_word_t out_in;
  logic [OCW-1:0]      out_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x   <= '0;
      cfg_q.origin_y   <= '0;
      cfg_q.origin_z   <= '0;
      cfg_q.inv_step_x <= 32'd65536;
      cfg_q.inv_step_y <= 32'd65536;
      cfg_q.inv_step_z <= 32'd65536;
      cfg_q.strength   <= 32'sd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fmti_pkg::CFG_ORIGIN_X:   cfg_q.origin_x   <= cfg_wdata_i;
        fmti_pkg::CFG_ORIGIN_Y:   cfg_q.origin_y   <= cfg_wdata_i;
        fmti_pkg::CFG_ORIGIN_Z:   cfg_q.origin_z   <= cfg_wdata_i;
        fmti_pkg::CFG_INV_STEP_X: cfg_q.inv_step_x <= cfg_wdata_i;
        fmti_pkg::CFG_INV_STEP_Y: cfg_q.inv_step_y <= cfg_wdata_i;
        fmti_pkg::CFG_INV_STEP_Z: cfg_q.inv_step_z <= cfg_wdata_i;
        fmti_pkg::CFG_STRENGTH:   cfg_q.strength   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  fmti_front #(
    .NX(NX), .NY(NY), .NZ(NZ), .FRAC_BITS(FRAC_BITS), .MID_DEPTH(MID_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .word_i      (in_word_i),
    .full_o      (full),
    .mid_count_i (mid_count),
    .mid_push_o  (mid_push),
    .mid_word_o  (mid_in)
  );

  fmti_queue #(
    .word_t(fmti_pkg::job_t), .DEPTH(MID_DEPTH)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .word_i  (mid_in),
    .pop_i   (mid_pop),
    .word_o  (mid_out),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  fmti_back #(
    .NX(NX), .NY(NY), .NZ(NZ), .FRAC_BITS(FRAC_BITS), .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_word_i  (mid_out),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .out_count_i (out_count),
    .out_push_o  (out_push),
    .out_word_o  (out_in)
  );

  assign out_pop = pop && !empty;

  fmti_queue #(
    .word_t(fmti_pkg::out_word_t), .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .word_i  (out_in),
    .pop_i   (out_pop),
    .word_o  (out_word_o),
    .empty_o (empty),
    .count_o (out_count)
  );

endmodule

// ----- sim/tb.sv -----
// Testbench for the trilinear field map lookup: scoreboard, stimulus and checks.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned GRID = 32;
  localparam int unsigned CELLS = GRID * GRID * GRID;

  class field_sb;
    int          tab_x[CELLS];
    int          tab_y[CELLS];
    int          tab_z[CELLS];
    bit          written[CELLS];
    logic [31:0] regs[7];
    fmti_pkg::out_word_t pending[$];
    int          errors;

    function new();
      regs = '{32'd0, 32'd0, 32'd0, 32'd65536, 32'd65536, 32'd65536, 32'd65536};
      errors = 0;
    endfunction

    function void set_reg(int idx, logic [31:0] val);
      regs[idx] = val;
    endfunction

    function bit locate(longint coord, logic [31:0] org, logic [31:0] inv,
                        output int idx, output longint fr);
      longint d;
      longint unsigned ud, a, b, p;
      d = coord - longint'(signed'(org));
      idx = 0;
      fr = 0;
      if (d < 0) return 0;
      ud = d;
      a = ud * longint'(inv[31:16]);
      b = ud * longint'(inv[15:0]);
      p = a + (b >> 16);
      if (p > (longint'(GRID - 1) << 16)) return 0;
      idx = int'(p >> 16);
      fr = longint'(p & 64'hFFFF);
      if (idx >= GRID - 1) begin
        idx = GRID - 2;
        fr = 65536;
      end
      return 1;
    endfunction

    function bit place(fmti_pkg::in_word_t w, output int ix, iy, iz,
                       output longint fx, fy, fz);
      longint u, v, mx, mz;
      ix = 0;
      iy = 0;
      iz = 0;
      fx = 0;
      fy = 0;
      fz = 0;
      u = longint'(w.pos_x) - longint'(fmti_pkg::OFS_X);
      v = longint'(w.pos_z) - longint'(fmti_pkg::OFS_Z);
      mx = (u * longint'(fmti_pkg::ROT_COS) - v * longint'(fmti_pkg::ROT_SIN)
            + (64'sd1 << 29)) >>> 30;
      mz = (u * longint'(fmti_pkg::ROT_SIN) + v * longint'(fmti_pkg::ROT_COS)
            + (64'sd1 << 29)) >>> 30;
      return locate(mx, regs[0], regs[3], ix, fx) &&
             locate(longint'(w.pos_y), regs[1], regs[4], iy, fy) &&
             locate(mz, regs[2], regs[5], iz, fz);
    endfunction

    function bit reads_written(fmti_pkg::in_word_t w);
      int ix, iy, iz;
      longint fx, fy, fz;
      int base;
      if (!place(w, ix, iy, iz, fx, fy, fz)) return 1;
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++) begin
          base = ((ix + i) * GRID + iy + j) * GRID + iz;
          if (!written[base] || !written[base + 1]) return 0;
        end
      return 1;
    endfunction

    function longint blend(longint a, longint b, longint f);
      return (a * (65536 - f) + b * f + 32768) >>> 16;
    endfunction

    function logic [31:0] field_at(ref int t[CELLS], input int ix, iy, iz,
                                   input longint fx, fy, fz);
      longint c[2][2];
      longint v, r;
      int base;
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++) begin
          base = ((ix + i) * GRID + iy + j) * GRID + iz;
          c[i][j] = blend(t[base], t[base + 1], fz);
        end
      v = blend(blend(c[0][0], c[0][1], fy), blend(c[1][0], c[1][1], fy), fx);
      r = (v * longint'(signed'(regs[6])) + 32768) >>> 16;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
    endfunction

    function void note(fmti_pkg::in_word_t w);
      longint fx, fy, fz;
      int ix, iy, iz;
      fmti_pkg::out_word_t res;
      if (w.cmd == fmti_pkg::CMD_LOAD) begin
        tab_x[w.entry_index] = w.sample_x;
        tab_y[w.entry_index] = w.sample_y;
        tab_z[w.entry_index] = w.sample_z;
        written[w.entry_index] = 1'b1;
        return;
      end
      res = '0;
      if (place(w, ix, iy, iz, fx, fy, fz)) begin
        res.field_x = field_at(tab_x, ix, iy, iz, fx, fy, fz);
        res.field_y = field_at(tab_y, ix, iy, iz, fx, fy, fz);
        res.field_z = field_at(tab_z, ix, iy, iz, fx, fy, fz);
        res.in_region = 1'b1;
      end
      pending.push_back(res);
    endfunction

    function void check(fmti_pkg::out_word_t r);
      fmti_pkg::out_word_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", r);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r.field_x !== e.field_x) begin
        $error("field_x expected %0d actual %0d", e.field_x, r.field_x);
        errors++;
      end
      if (r.field_y !== e.field_y) begin
        $error("field_y expected %0d actual %0d", e.field_y, r.field_y);
        errors++;
      end
      if (r.field_z !== e.field_z) begin
        $error("field_z expected %0d actual %0d", e.field_z, r.field_z);
        errors++;
      end
      if (r.in_region !== e.in_region) begin
        $error("in_region expected %0b actual %0b", e.in_region, r.in_region);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  fmti_pkg::in_word_t  in_word;
  logic        empty;
  logic        pop;
  fmti_pkg::out_word_t out_word;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_wdata;
  bit          idling;
  field_sb     sb;

  field_map_trilinear_interp_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_word_i   (in_word),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idling && $urandom_range(0, 5) == 0) begin
        pop = 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk_i);
      end else begin
        pop = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check(out_word);
  end

  // corner blocks of every axis: cells 0..2 and GRID-3..GRID-1
  function automatic int block_coord(int n);
    return (n < 3) ? n : GRID - 6 + n;
  endfunction

  function automatic int block_index();
    int bx, by, bz;
    bx = block_coord($urandom_range(0, 5));
    by = block_coord($urandom_range(0, 5));
    bz = block_coord($urandom_range(0, 5));
    return (bx * GRID + by) * GRID + bz;
  endfunction

  function automatic fmti_pkg::in_word_t load_word(int idx, int sx, int sy, int sz);
    fmti_pkg::in_word_t w;
    w = '0;
    w.cmd = fmti_pkg::CMD_LOAD;
    w.entry_index = idx[14:0];
    w.sample_x = sx[23:0];
    w.sample_y = sy[23:0];
    w.sample_z = sz[23:0];
    w.pos_x = $urandom;
    w.pos_y = $urandom;
    w.pos_z = $urandom;
    return w;
  endfunction

  task automatic send(fmti_pkg::in_word_t w);
    if (w.cmd == fmti_pkg::CMD_QUERY && !sb.reads_written(w))
      w = load_word(block_index(), $urandom, $urandom, $urandom);
    if (idling && $urandom_range(0, 5) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    push = 1'b1;
    in_word = w;
    do @(posedge clk_i); while (full);
    sb.note(w);
    @(negedge clk_i);
  endtask

  task automatic drain();
    push = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (24) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  function automatic fmti_pkg::in_word_t raw_query(longint px, py, pz);
    fmti_pkg::in_word_t w;
    w = '0;
    w.cmd = fmti_pkg::CMD_QUERY;
    w.entry_index = $urandom;
    w.sample_x = $urandom;
    w.sample_y = $urandom;
    w.sample_z = $urandom;
    w.pos_x = px[31:0];
    w.pos_y = py[31:0];
    w.pos_z = pz[31:0];
    return w;
  endfunction

  function automatic longint clip32(real r);
    if (r > 2147483647.0) return 64'sd2147483647;
    if (r < -2147483648.0) return -64'sd2147483648;
    return longint'(r);
  endfunction

  function automatic real map_coord(real c, logic [31:0] org, logic [31:0] inv);
    if (inv == 0) return real'(signed'(org)) + $urandom_range(0, 200000);
    return real'(signed'(org)) + c * 4294967296.0 / real'(inv);
  endfunction

  // aim at cell coordinates (cx, cy, cz) in the map frame
  function automatic fmti_pkg::in_word_t aimed_query(real cx, cy, cz);
    real mx, my, mz, sn, cs;
    sn = real'(fmti_pkg::ROT_SIN) / 1073741824.0;
    cs = real'(fmti_pkg::ROT_COS) / 1073741824.0;
    mx = map_coord(cx, sb.regs[0], sb.regs[3]);
    my = map_coord(cy, sb.regs[1], sb.regs[4]);
    mz = map_coord(cz, sb.regs[2], sb.regs[5]);
    return raw_query(clip32(mx * cs + mz * sn + real'(fmti_pkg::OFS_X)), clip32(my),
                     clip32(-mx * sn + mz * cs + real'(fmti_pkg::OFS_Z)));
  endfunction

  function automatic real rand_cell();
    real r;
    r = real'($urandom_range(0, 2400)) / 1000.0;
    if ($urandom_range(0, 1) == 1) return 29.1 + r;
    return r - 0.5;
  endfunction

  task automatic random_phase(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 25)
        send(load_word($urandom_range(0, CELLS - 1), $urandom, $urandom, $urandom));
      else if (r < 85)
        send(aimed_query(rand_cell(), rand_cell(), rand_cell()));
      else
        send(raw_query(int'($urandom), int'($urandom), int'($urandom)));
    end
  endtask

  task automatic set_all(logic [31:0] ox, oy, oz, sx, sy, sz, st);
    drain();
    write_reg(fmti_pkg::CFG_ORIGIN_X, ox);
    write_reg(fmti_pkg::CFG_ORIGIN_Y, oy);
    write_reg(fmti_pkg::CFG_ORIGIN_Z, oz);
    write_reg(fmti_pkg::CFG_INV_STEP_X, sx);
    write_reg(fmti_pkg::CFG_INV_STEP_Y, sy);
    write_reg(fmti_pkg::CFG_INV_STEP_Z, sz);
    write_reg(fmti_pkg::CFG_STRENGTH, st);
  endtask

  initial begin
    int waited;
    sb = new();
    push = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    idling = 1'b1;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // fill the low and high corner blocks of every axis
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 6; j++)
        for (int k = 0; k < 6; k++)
          send(load_word((block_coord(i) * GRID + block_coord(j)) * GRID + block_coord(k),
                         $urandom, $urandom, $urandom));
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        for (int k = 0; k < 2; k++) begin
          send(load_word((i * GRID + j) * GRID + k, 8388607, -8388608,
                         ((i + j + k) % 2) ? 8388607 : -8388608));
        end

    send(aimed_query(0.0, 0.0, 0.0));
    send(aimed_query(0.5, 0.5, 0.5));
    send(aimed_query(30.9, 30.9, 30.9));
    send(raw_query(longint'(fmti_pkg::OFS_X) + 65536, 31 <<< 16,
                   longint'(fmti_pkg::OFS_Z) + 65536));
    send(raw_query(longint'(fmti_pkg::OFS_X) + 65536, -1,
                   longint'(fmti_pkg::OFS_Z) + 65536));
    send(raw_query(longint'(fmti_pkg::OFS_X) + 65536, (31 <<< 16) + 1,
                   longint'(fmti_pkg::OFS_Z) + 65536));
    send(raw_query(longint'(fmti_pkg::OFS_X) + 65536, 32 <<< 16,
                   longint'(fmti_pkg::OFS_Z) + 65536));
    send(raw_query(64'sd2147483647, 64'sd2147483647, 64'sd2147483647));
    send(raw_query(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648));
    send(raw_query(0, 0, 0));
    send(aimed_query(-0.3, 5.0, 5.0));
    send(aimed_query(5.0, 5.0, 31.5));

    random_phase(70);
    set_all(-32'sd327680, -32'sd196608, -32'sd524288, 32'd131072, 32'd98304,
            32'd32768, -32'sd196608);
    random_phase(70);
    set_all(0, 0, 0, 0, 0, 0, 32'h7FFFFFFF);
    send(aimed_query(0.0, 0.0, 0.0));
    random_phase(60);
    set_all(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
            32'hFFFFFFFF, 32'h80000000);
    random_phase(40);
    set_all(0, 32'h7FFFFFFF, 0, 32'hFFFFFFFF, 32'h10000, 32'hFFFFFFFF, 32'h80000000);
    random_phase(40);
    set_all(0, 0, 0, 32'd65536, 32'd65536, 32'd65536, 32'd6553600);
    send(aimed_query(0.5, 0.5, 0.5));
    idling = 1'b0;
    random_phase(80);

    push = 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (40) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
